>>> sv/arlc_pkg.sv
// ----------------------------------------------------------------------------
// AT response line classifier package
// Shared widths, character codes, event codes and controller types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arlc_pkg;

   localparam int LINE_BYTES_DEFAULT = 64;

   localparam int CNT_W  = 7;
   localparam int BYTE_W = 8;
   localparam int EV_W   = 3;

   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_O     = 8'h4F;
   localparam logic [BYTE_W-1:0] CHAR_K     = 8'h4B;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
   localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3E;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EV_W-1:0] EV_OK      = 3'd1;
   localparam logic [EV_W-1:0] EV_ERROR   = 3'd2;
   localparam logic [EV_W-1:0] EV_PROMPT  = 3'd3;
   localparam logic [EV_W-1:0] EV_LINE    = 3'd4;
   localparam logic [EV_W-1:0] EV_CAPTURE = 3'd5;

   localparam logic [CNT_W-1:0] LEN_OK     = 7'd3;
   localparam logic [CNT_W-1:0] LEN_ERROR  = 7'd6;
   localparam logic [CNT_W-1:0] LEN_PROMPT = 7'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } arlc_state_type;

   typedef struct packed {
      logic take;
      logic rd;
      logic emit;
   } arlc_cmd_type;

   typedef struct packed {
      logic stream_start;
      logic out_free;
      logic emit_last;
   } arlc_sts_type;

endpackage

`default_nettype wire

>>> sv/arlc_ctrl.sv
// ----------------------------------------------------------------------------
// AT response line classifier controller
// Sequences acceptance of transactions and the byte-by-byte line stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arlc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  arlc_pkg::arlc_sts_type sts,
   output arlc_pkg::arlc_cmd_type cmd
);

   arlc_pkg::arlc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arlc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         arlc_pkg::ST_IDLE: begin
            req_ready = sts.out_free;
            cmd.take  = req_valid && sts.out_free;
            if (cmd.take && sts.stream_start) begin
               state_in = arlc_pkg::ST_READ;
            end
         end
         arlc_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = arlc_pkg::ST_EMIT;
         end
         arlc_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.emit_last ? arlc_pkg::ST_IDLE : arlc_pkg::ST_READ;
            end
         end
         default: begin
            state_in = arlc_pkg::ST_IDLE;
         end
      endcase
   end

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && sts.emit_last |=> state_ff == arlc_pkg::ST_IDLE)
      else $error("stream did not end after its last byte");

   a_emit_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> state_ff == arlc_pkg::ST_EMIT)
      else $error("memory read not followed by emit state");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == arlc_pkg::ST_IDLE)
      else $error("request accepted outside idle state");

endmodule

`default_nettype wire

>>> sv/arlc_datapath.sv
// ----------------------------------------------------------------------------
// AT response line classifier datapath
// Line store, header shadow bytes, classification and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arlc_datapath #(
   parameter int LINE_BYTES = arlc_pkg::LINE_BYTES_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  arlc_pkg::arlc_cmd_type              cmd,
   output arlc_pkg::arlc_sts_type              sts,
   input  wire                                 req_command,
   input  wire  [arlc_pkg::BYTE_W-1:0]         req_rx_byte,
   input  wire                                 req_parity_error,
   input  wire  [arlc_pkg::CNT_W-1:0]          req_capture_length,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [arlc_pkg::EV_W-1:0]           rsp_event_res,
   output logic [arlc_pkg::BYTE_W-1:0]         rsp_line_byte,
   output logic [arlc_pkg::CNT_W-1:0]          rsp_line_length,
   output logic                                rsp_last
);

   localparam int AW     = $clog2(LINE_BYTES);
   localparam int CNT_W  = arlc_pkg::CNT_W;
   localparam int BYTE_W = arlc_pkg::BYTE_W;
   localparam int HDR_N  = 5;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_BYTES);

   logic [BYTE_W-1:0] mem [LINE_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] hdr_ff [HDR_N];

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_cr_ff;
   logic [CNT_W-1:0]  len_ff;
   logic [CNT_W-1:0]  run_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic              capmode_ff;
   logic              zeroed_ff;

   logic [arlc_pkg::EV_W-1:0] ev_ff;
   logic [BYTE_W-1:0]         byte_ff;
   logic [CNT_W-1:0]          length_ff;
   logic                      last_ff;

   logic              is_byte, eol, is_ok, is_err, is_stream, can_store, is_prompt;
   logic              load_single;
   logic [CNT_W-1:0]  run_in;
   logic [BYTE_W-1:0] stream_byte;
   logic [arlc_pkg::EV_W-1:0] single_ev;
   logic [CNT_W-1:0]  single_len;

   always_comb begin
      is_byte   = !req_command && !req_parity_error;
      eol       = is_byte && (req_rx_byte == arlc_pkg::CHAR_LF) && (cnt_ff != '0)
                  && last_cr_ff;
      is_ok     = eol && (cnt_ff == arlc_pkg::LEN_OK) && (hdr_ff[0] == arlc_pkg::CHAR_O)
                  && (hdr_ff[1] == arlc_pkg::CHAR_K);
      is_err    = eol && (cnt_ff == arlc_pkg::LEN_ERROR)
                  && (hdr_ff[0] == arlc_pkg::CHAR_E) && (hdr_ff[1] == arlc_pkg::CHAR_R)
                  && (hdr_ff[2] == arlc_pkg::CHAR_R) && (hdr_ff[3] == arlc_pkg::CHAR_O)
                  && (hdr_ff[4] == arlc_pkg::CHAR_R);
      is_stream = eol && !is_ok && !is_err && (cnt_ff > CNT_W'(2));
      can_store = is_byte && !eol && (cnt_ff < CNT_MAX);
      is_prompt = can_store && (cnt_ff == CNT_W'(1)) && (hdr_ff[0] == arlc_pkg::CHAR_GT)
                  && (req_rx_byte == arlc_pkg::CHAR_SPACE);

      if (cap_ff == '0) begin
         run_in = cnt_ff;
      end else begin
         run_in = (cap_ff < cnt_ff) ? cap_ff : cnt_ff;
      end

      priority if (is_ok) begin
         single_ev  = arlc_pkg::EV_OK;
         single_len = arlc_pkg::LEN_OK;
      end else if (is_err) begin
         single_ev  = arlc_pkg::EV_ERROR;
         single_len = arlc_pkg::LEN_ERROR;
      end else if (is_prompt) begin
         single_ev  = arlc_pkg::EV_PROMPT;
         single_len = arlc_pkg::LEN_PROMPT;
      end else begin
         single_ev  = arlc_pkg::EV_NONE;
         single_len = '0;
      end

      stream_byte = (capmode_ff && zeroed_ff) ? '0 : rd_data_ff;
      load_single = cmd.take && !is_stream;

      sts.stream_start = is_stream;
      sts.out_free     = !rsp_valid_ff || rsp_ready;
      sts.emit_last    = (idx_ff + CNT_W'(1)) == run_ff;
   end

   always_comb begin
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.take) begin
         if (req_command) begin
            cap_in = req_capture_length;
         end
         if (eol || is_prompt) begin
            cnt_in = '0;
         end else if (can_store) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (is_stream) begin
            cap_in = '0;
         end
      end
      if (load_single || cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && can_store) begin
         mem[cnt_ff[AW-1:0]] <= req_rx_byte;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && can_store) begin
         last_cr_ff <= req_rx_byte == arlc_pkg::CHAR_CR;
         for (int k = 0; k < HDR_N; k++) begin
            if (cnt_ff == CNT_W'(k)) begin
               hdr_ff[k] <= req_rx_byte;
            end
         end
      end
      if (cmd.take && is_stream) begin
         len_ff     <= cnt_ff;
         run_ff     <= run_in;
         capmode_ff <= cap_ff != '0;
         idx_ff     <= '0;
         zeroed_ff  <= 1'b0;
      end
      if (cmd.emit) begin
         idx_ff <= idx_ff + CNT_W'(1);
         if (stream_byte == '0) begin
            zeroed_ff <= 1'b1;
         end
      end
      if (load_single) begin
         ev_ff     <= single_ev;
         byte_ff   <= '0;
         length_ff <= single_len;
         last_ff   <= 1'b1;
      end else if (cmd.emit) begin
         ev_ff     <= capmode_ff ? arlc_pkg::EV_CAPTURE : arlc_pkg::EV_LINE;
         byte_ff   <= stream_byte;
         length_ff <= len_ff;
         last_ff   <= sts.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = ev_ff;
   assign rsp_line_byte   = byte_ff;
   assign rsp_line_length = length_ff;
   assign rsp_last        = last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("line count beyond store size");

   a_emit_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> idx_ff < run_ff)
      else $error("stream index past run length");

   a_run_fits_line: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> run_ff <= len_ff && len_ff <= CNT_MAX)
      else $error("run longer than stored line");

   a_no_load_over_held: assert property (@(posedge clock) disable iff (reset)
      (load_single || cmd.emit) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

endmodule

`default_nettype wire

>>> sv/at_response_line_classifier_top.sv
// ----------------------------------------------------------------------------
// AT response line classifier top level
// Sorts modem receive bytes into ok, error, prompt, line and capture events.
// ----------------------------------------------------------------------------
// Request channel (req_): one transaction carries a received byte with its
// parity flag, or an arm-capture command with a length. Response channel
// (rsp_): one transaction per result; rsp_last marks the final result that a
// request causes. Both channels use valid/ready.
// A request that gives one result (none, ok, error, prompt) is accepted and
// its result is registered for the next cycle, so such requests flow at
// one per cycle while rsp_ready stays high.
// A line end on a stored line longer than two bytes that is not ok or error
// streams the line (in capture mode, only the armed run): each byte is read
// from the single read port of the line store, then loaded into the result
// register; req_ready stays low until the last byte is loaded.
// When rsp_ready is low, a held result blocks new requests and stalls the
// stream in place. Reset empties the line, disarms capture and drops any
// pending result; the line store itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module at_response_line_classifier_top #(
   parameter int LINE_BYTES = arlc_pkg::LINE_BYTES_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_command,
   input  wire  [arlc_pkg::BYTE_W-1:0]  req_rx_byte,
   input  wire                          req_parity_error,
   input  wire  [arlc_pkg::CNT_W-1:0]   req_capture_length,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [arlc_pkg::EV_W-1:0]    rsp_event_res,
   output logic [arlc_pkg::BYTE_W-1:0]  rsp_line_byte,
   output logic [arlc_pkg::CNT_W-1:0]   rsp_line_length,
   output logic                         rsp_last
);

   arlc_pkg::arlc_cmd_type cmd;
   arlc_pkg::arlc_sts_type sts;

   arlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   arlc_datapath #(
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_command        (req_command),
      .req_rx_byte        (req_rx_byte),
      .req_parity_error   (req_parity_error),
      .req_capture_length (req_capture_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_line_byte      (rsp_line_byte),
      .rsp_line_length    (rsp_line_length),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response line classifier testbench
// Sends modem bytes and capture commands through the request channel, builds
// the expected event stream with an in-bench line predictor and checks every
// response transaction field by field, with random idles on both channels.
// ----------------------------------------------------------------------------

module testbench;
   import arlc_pkg::*;

   localparam int LINE_BYTES  = LINE_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int BURST_REQS  = 200;
   localparam int TOTAL_REQS  = 400;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic [EV_W-1:0]   ev;
      logic [BYTE_W-1:0] lbyte;
      logic [CNT_W-1:0]  len;
      logic              last;
   } line_event_type;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_command        = 1'b0;
   logic [BYTE_W-1:0]  req_rx_byte        = '0;
   logic               req_parity_error   = 1'b0;
   logic [CNT_W-1:0]   req_capture_length = '0;
   logic               rsp_ready          = 1'b0;
   wire                req_ready;
   wire                rsp_valid;
   wire  [EV_W-1:0]    rsp_event_res;
   wire  [BYTE_W-1:0]  rsp_line_byte;
   wire  [CNT_W-1:0]   rsp_line_length;
   wire                rsp_last;

   line_event_type    expected_events[$];
   logic [BYTE_W-1:0] line_buf [LINE_BYTES];
   int                line_fill  = 0;
   int                armed_len  = 0;
   int                mismatches = 0;
   int                reqs_sent  = 0;
   int                cycles     = 0;
   bit                idle_en    = 1'b1;

   at_response_line_classifier_top #(
      .LINE_BYTES(LINE_BYTES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_rx_byte       (req_rx_byte),
      .req_parity_error  (req_parity_error),
      .req_capture_length(req_capture_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_line_byte     (rsp_line_byte),
      .rsp_line_length   (rsp_line_length),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !idle_en || ($urandom_range(0, 99) >= 28);
   end

   task automatic report_mismatch(input string field, input int got, input int want);
      if (mismatches < 40)
         $display("cycle %0d: %s mismatch, got %0d expected %0d", cycles, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_events
      line_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected transaction event_res", int'(rsp_event_res), -1);
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_res !== want.ev)
               report_mismatch("event_res", int'(rsp_event_res), int'(want.ev));
            if (rsp_line_byte !== want.lbyte)
               report_mismatch("line_byte", int'(rsp_line_byte), int'(want.lbyte));
            if (rsp_line_length !== want.len)
               report_mismatch("line_length", int'(rsp_line_length), int'(want.len));
            if (rsp_last !== want.last)
               report_mismatch("last", int'(rsp_last), int'(want.last));
         end
      end
   end

   function automatic void expect_event(input logic [EV_W-1:0] ev,
                                        input logic [BYTE_W-1:0] lbyte,
                                        input int len, input logic last);
      line_event_type e;
      e.ev    = ev;
      e.lbyte = lbyte;
      e.len   = len[CNT_W-1:0];
      e.last  = last;
      expected_events.push_back(e);
   endfunction

   function automatic void classify_req(input logic cmd, input logic [BYTE_W-1:0] rxb,
                                        input logic perr, input logic [CNT_W-1:0] cap);
      int                run;
      logic              zeroed;
      logic [BYTE_W-1:0] b;
      if (cmd) begin
         armed_len = int'(cap);
         expect_event(EV_NONE, '0, 0, 1'b1);
      end else if (perr) begin
         expect_event(EV_NONE, '0, 0, 1'b1);
      end else if (rxb == CHAR_LF && line_fill > 0 && line_buf[line_fill-1] == CHAR_CR) begin
         if (line_fill == int'(LEN_OK) && line_buf[0] == CHAR_O && line_buf[1] == CHAR_K) begin
            expect_event(EV_OK, '0, int'(LEN_OK), 1'b1);
         end else if (line_fill == int'(LEN_ERROR) && line_buf[0] == CHAR_E &&
                      line_buf[1] == CHAR_R && line_buf[2] == CHAR_R &&
                      line_buf[3] == CHAR_O && line_buf[4] == CHAR_R) begin
            expect_event(EV_ERROR, '0, int'(LEN_ERROR), 1'b1);
         end else if (line_fill > 2) begin
            if (armed_len != 0) begin
               run    = (armed_len < line_fill) ? armed_len : line_fill;
               zeroed = 1'b0;
               for (int i = 0; i < run; i++) begin
                  b = zeroed ? '0 : line_buf[i];
                  if (b == '0)
                     zeroed = 1'b1;
                  expect_event(EV_CAPTURE, b, line_fill, i == run - 1);
               end
               armed_len = 0;
            end else begin
               for (int i = 0; i < line_fill; i++)
                  expect_event(EV_LINE, line_buf[i], line_fill, i == line_fill - 1);
            end
         end else begin
            expect_event(EV_NONE, '0, 0, 1'b1);
         end
         line_fill = 0;
      end else begin
         if (line_fill < LINE_BYTES) begin
            line_buf[line_fill] = rxb;
            line_fill++;
         end
         if (line_fill == int'(LEN_PROMPT) && line_buf[0] == CHAR_GT &&
             line_buf[1] == CHAR_SPACE) begin
            line_fill = 0;
            expect_event(EV_PROMPT, '0, int'(LEN_PROMPT), 1'b1);
         end else begin
            expect_event(EV_NONE, '0, 0, 1'b1);
         end
      end
   endfunction

   task automatic send_req(input logic cmd, input logic [BYTE_W-1:0] rxb,
                           input logic perr, input logic [CNT_W-1:0] cap);
      while (idle_en && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_rx_byte        <= rxb;
      req_parity_error   <= perr;
      req_capture_length <= cap;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      classify_req(cmd, rxb, perr, cap);
      reqs_sent++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      send_req(1'b0, b, 1'b0, CNT_W'($urandom_range(0, 64)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   task automatic send_noise();
      send_req(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 64)));
   endtask

   function automatic int pick_capture();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 64;
         2: return $urandom_range(1, 4);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_events.size() != 0);
   endtask

   task automatic send_random_sequence();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      if (line_fill > 50) begin
         send_byte(CHAR_CR);
         send_byte(CHAR_LF);
      end else if (kind < 10) begin
         send_line("OK");
      end else if (kind < 17) begin
         send_line("ERROR");
      end else if (kind < 23) begin
         send_text("> ");
      end else if (kind < 30) begin
         repeat ($urandom_range(1, 4))
            send_noise();
      end else begin
         if ($urandom_range(0, 2) == 0)
            send_req(1'b1, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     CNT_W'(pick_capture()));
         len = ($urandom_range(0, 15) == 0) ? 63 - line_fill : int'($urandom_range(0, 10));
         if (len > 63 - line_fill)
            len = 63 - line_fill;
         repeat (len) begin
            if ($urandom_range(0, 19) == 0)
               send_req(1'b0, BYTE_W'($urandom_range(0, 255)), 1'b1,
                        CNT_W'($urandom_range(0, 64)));
            send_byte(($urandom_range(0, 9) == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255)));
         end
         send_byte(CHAR_CR);
         if (line_fill == LINE_BYTES) begin
            repeat ($urandom_range(0, 3))
               send_byte(BYTE_W'($urandom_range(11, 255)));
         end else if (line_fill <= 56 && $urandom_range(0, 9) == 0) begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
         end
         send_byte(CHAR_LF);
      end
   endtask

   task automatic test_ok_and_error();
      send_line("OK");
      send_line("ERROR");
   endtask

   task automatic test_prompt();
      send_text("> ");
   endtask

   task automatic test_parity_and_short_line();
      send_req(1'b0, 8'hFF, 1'b1, 7'd64);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   task automatic test_capture();
      send_req(1'b1, 8'hA5, 1'b1, 7'd64);
      send_byte("A");
      send_byte(8'h00);
      send_byte("B");
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      send_req(1'b1, 8'h5A, 1'b0, 7'd0);
      send_line("AB");
   endtask

   task automatic test_store_full();
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1)
            send_req(1'b1, BYTE_W'($urandom_range(0, 255)), 1'b0, 7'd64);
         repeat (LINE_BYTES - 1)
            send_byte(BYTE_W'($urandom_range(1, 255)));
         send_byte(CHAR_CR);
         repeat (3)
            send_byte(BYTE_W'($urandom_range(11, 255)));
         send_byte(CHAR_LF);
      end
   endtask

   task automatic test_random_back_to_back();
      idle_en = 1'b0;
      while (reqs_sent < BURST_REQS)
         send_random_sequence();
      idle_en = 1'b1;
   endtask

   task automatic test_random_traffic();
      while (reqs_sent < TOTAL_REQS)
         send_random_sequence();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_ok_and_error();
      test_prompt();
      test_parity_and_short_line();
      test_capture();
      hold_until_drained();
      test_store_full();
      test_random_back_to_back();
      hold_until_drained();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/arlc_pkg.sv
sv/arlc_ctrl.sv
sv/arlc_datapath.sv
sv/at_response_line_classifier_top.sv
tb/sv/testbench.sv
